// ===== src/stepper_full_step_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stepper sequencer core
// Shared property forms, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_FULL_STEP_SEQUENCER_CORE_MACROS_SVH
`define STEPPER_FULL_STEP_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication
`define STPSEQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stepper sequencer: same-cycle check failed");

// Next-cycle implication
`define STPSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stepper sequencer: next-cycle check failed");

`endif

// ===== src/stpseq_pkg.sv =====
// ----------------------------------------------------------------------------
// stpseq_pkg
// Types, codes and constants shared by the stepper sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stpseq_pkg;

   localparam int INTERVAL_BITS  = 10;
   localparam int SPEED_BITS     = 10;
   localparam int CYCLES_IN_BITS = 16;
   localparam int PHASE_BITS     = 2;
   localparam int COIL_BITS      = 4;

   localparam logic [SPEED_BITS-1:0] SPEED_CLAMP = 10'd1000;

   // input kinds carried on tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic [COIL_BITS-1:0] STEP_TABLE [4] = '{4'd9, 4'd5, 4'd6, 4'd10};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic                     start;
      logic [INTERVAL_BITS-1:0] dividend;
      logic [SPEED_BITS-1:0]    divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic [INTERVAL_BITS-1:0] quotient;
   } div_status_type;

   // Forward order walks the table up, reverse walks it down.
   function automatic logic [COIL_BITS-1:0] pattern_at(
      input logic                  fwd,
      input logic [PHASE_BITS-1:0] ph
   );
      logic [PHASE_BITS-1:0] idx;
      idx = fwd ? ph : ~ph;
      return STEP_TABLE[idx];
   endfunction

endpackage

// ===== src/stpseq_divider.sv =====
// ----------------------------------------------------------------------------
// stpseq_divider
// Restoring divider, one quotient bit per cycle through one subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpseq_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  stpseq_pkg::div_ctrl_type     ctrl,
   output stpseq_pkg::div_status_type   status
);

   localparam int W        = stpseq_pkg::INTERVAL_BITS;
   localparam int CNT_BITS = $clog2(W + 1);

   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        quo_ff, quo_in;
   logic [W-1:0]        dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [W:0]          shifted;
   logic [W:0]          diff;
   logic                ge;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = ctrl.dividend;
         dvs_in  = W'(ctrl.divisor);
         cnt_in  = CNT_BITS'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit drops
         rem_in = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

// ===== src/stepper_full_step_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// stepper_full_step_sequencer_core
// Full-step sequencer for four coil lines, driven by run commands and ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per command or millisecond tick; tuser
//   selects the kind (0 tick, 1 run command). rsp_* returns exactly one
//   transaction per request: coil drive, busy flag and command-loaded flag.
//   A run command is loaded only while idle with nonzero speed and cycles;
//   its interval TICKS_PER_SECOND / min(speed, 1000) comes from a restoring
//   divider that yields one quotient bit per cycle.
//   An accepted request passes through ST_EXEC and, for a loaded command,
//   through ST_DIVIDE while the divider runs; ST_OUTPUT then fills the
//   output register behind rsp_tvalid. The block takes one request at a
//   time, so a loaded command holds off the next one until the divider
//   is done. req_tready rises again once the result sits in the output register,
//   even while rsp_tready is low; a further result waits until that register is taken.
//   Reset (synchronous) clears the phase, the cycle count and the coils
//   and drops any pending response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stepper_full_step_sequencer_core_macros.svh"

module stepper_full_step_sequencer_core #(
   parameter int TICKS_PER_SECOND = 1000,
   parameter int CYCLE_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] direction, [10:1] speed, [26:11] cycles, [31:27] zero
   input  logic [31:0] req_tdata,
   // [0] operation
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] coil_pattern, [4] busy_res, [5] accepted, [7:6] zero
   output logic [7:0]  rsp_tdata
);

   localparam int IW      = stpseq_pkg::INTERVAL_BITS;
   localparam int SW      = stpseq_pkg::SPEED_BITS;
   localparam int PW      = stpseq_pkg::PHASE_BITS;
   localparam int CW      = stpseq_pkg::COIL_BITS;
   localparam int CIN     = stpseq_pkg::CYCLES_IN_BITS;
   localparam int CCB     = CYCLE_COUNT_BITS;
   localparam int CYC_EXT = (CCB > CIN) ? CCB : CIN;

   stpseq_pkg::state_type state_ff, state_in;

   // captured request
   logic           op_ff, op_in;
   logic           dir_ff, dir_in;
   logic [SW-1:0]  speed_ff, speed_in;
   logic [CCB-1:0] cycles_ff, cycles_in;

   // sequencer state
   logic [PW-1:0]  phase_ff, phase_in;
   logic [CCB-1:0] remaining_ff, remaining_in;
   logic           run_dir_ff, run_dir_in;
   logic [IW-1:0]  interval_ff, interval_in;
   logic [IW-1:0]  countdown_ff, countdown_in;
   logic [CW-1:0]  coil_ff, coil_in;
   logic           accepted_ff, accepted_in;

   logic           rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]     rsp_tdata_ff, rsp_tdata_in;

   // FSM outputs
   logic           capture;
   logic           do_tick;
   logic           do_load;
   logic           set_rsp;
   logic           clr_accepted;

   logic                       cmd_ok;
   logic                       slot_free;
   logic [CYC_EXT-1:0]         cyc_wide;
   logic [SW-1:0]              divisor;
   logic [IW-1:0]              iv;
   logic [PW-1:0]              ph_next;
   logic [CCB-1:0]             rem_dec;
   stpseq_pkg::div_ctrl_type   div_ctrl;
   stpseq_pkg::div_status_type div_stat;

   assign cyc_wide  = CYC_EXT'(req_tdata[26:11]);
   assign cmd_ok    = (op_ff == stpseq_pkg::OP_RUN) && (remaining_ff == '0)
                      && (speed_ff != '0) && (cycles_ff != '0);
   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign divisor   = (speed_ff > stpseq_pkg::SPEED_CLAMP) ? stpseq_pkg::SPEED_CLAMP
                                                           : speed_ff;
   assign iv        = (div_stat.quotient == '0) ? IW'(1) : div_stat.quotient;
   assign ph_next   = phase_ff + PW'(1);
   assign rem_dec   = remaining_ff - CCB'(1);

   assign div_ctrl.start    = do_load ? 1'b0 : (state_ff == stpseq_pkg::ST_EXEC) && cmd_ok;
   assign div_ctrl.dividend = IW'(TICKS_PER_SECOND);
   assign div_ctrl.divisor  = divisor;

   stpseq_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (div_ctrl),
      .status (div_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stpseq_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = stpseq_pkg::ST_EXEC;
         end
         stpseq_pkg::ST_EXEC: begin
            state_in = cmd_ok ? stpseq_pkg::ST_DIVIDE : stpseq_pkg::ST_OUTPUT;
         end
         stpseq_pkg::ST_DIVIDE: begin
            if (div_stat.done) state_in = stpseq_pkg::ST_OUTPUT;
         end
         stpseq_pkg::ST_OUTPUT: begin
            if (slot_free) state_in = stpseq_pkg::ST_IDLE;
         end
         default: state_in = stpseq_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready   = 1'b0;
      capture      = 1'b0;
      do_tick      = 1'b0;
      do_load      = 1'b0;
      set_rsp      = 1'b0;
      clr_accepted = 1'b0;
      unique case (state_ff)
         stpseq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            capture    = req_tvalid;
         end
         stpseq_pkg::ST_EXEC: begin
            clr_accepted = 1'b1;
            do_tick      = (op_ff == stpseq_pkg::OP_TICK) && (remaining_ff != '0);
         end
         stpseq_pkg::ST_DIVIDE: begin
            do_load = div_stat.done;
         end
         stpseq_pkg::ST_OUTPUT: begin
            set_rsp = slot_free;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      op_in        = op_ff;
      dir_in       = dir_ff;
      speed_in     = speed_ff;
      cycles_in    = cycles_ff;
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      run_dir_in   = run_dir_ff;
      interval_in  = interval_ff;
      countdown_in = countdown_ff;
      coil_in      = coil_ff;
      accepted_in  = accepted_ff;

      if (capture) begin
         op_in     = req_tuser;
         dir_in    = req_tdata[0];
         speed_in  = req_tdata[10:1];
         cycles_in = cyc_wide[CCB-1:0];
      end

      if (clr_accepted) accepted_in = 1'b0;

      if (do_tick) begin
         if (countdown_ff > IW'(1)) begin
            countdown_in = countdown_ff - IW'(1);
         end else begin
            phase_in     = ph_next;
            coil_in      = stpseq_pkg::pattern_at(run_dir_ff, ph_next);
            countdown_in = interval_ff;
            if (ph_next == '0) begin
               remaining_in = rem_dec;
               // last cycle used up: coils off
               if (rem_dec == '0) begin
                  coil_in      = '0;
                  countdown_in = '0;
               end
            end
         end
      end

      if (do_load) begin
         remaining_in = cycles_ff;
         run_dir_in   = dir_ff;
         interval_in  = iv;
         countdown_in = iv;
         coil_in      = stpseq_pkg::pattern_at(dir_ff, phase_ff);
         accepted_in  = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tready) rsp_tvalid_in = 1'b0;
      if (set_rsp) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {2'b00, accepted_ff, (remaining_ff != '0), coil_ff};
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      dir_ff       <= dir_in;
      speed_ff     <= speed_in;
      cycles_ff    <= cycles_in;
      rsp_tdata_ff <= rsp_tdata_in;
      if (reset) begin
         state_ff      <= stpseq_pkg::ST_IDLE;
         phase_ff      <= '0;
         remaining_ff  <= '0;
         run_dir_ff    <= 1'b0;
         interval_ff   <= '0;
         countdown_ff  <= '0;
         coil_ff       <= '0;
         accepted_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         remaining_ff  <= remaining_in;
         run_dir_ff    <= run_dir_in;
         interval_ff   <= interval_in;
         countdown_ff  <= countdown_in;
         coil_ff       <= coil_in;
         accepted_ff   <= accepted_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `STPSEQ_ASSERT_IMPLIES(a_coils_off_when_idle, clock, reset,
      remaining_ff == '0, coil_ff == '0)
   `STPSEQ_ASSERT_IMPLIES(a_divider_only_in_divide, clock, reset,
      div_stat.busy || div_stat.done, state_ff == stpseq_pkg::ST_DIVIDE)
   `STPSEQ_ASSERT_IMPLIES(a_loaded_means_busy, clock, reset,
      rsp_tvalid_ff && rsp_tdata_ff[5], rsp_tdata_ff[4])
   `STPSEQ_ASSERT_NEXT(a_load_leads_to_output, clock, reset,
      do_load, state_ff == stpseq_pkg::ST_OUTPUT && accepted_ff)

endmodule
